FILE: hdl/hfr_pkg.sv
`default_nettype none

package hfr_pkg;

  localparam int unsigned POS_BITS       = 16;
  localparam int unsigned UNIT_BITS      = 16;
  localparam int unsigned REPORT_BITS    = 17;
  localparam int unsigned DIST_BITS      = 18;
  localparam int unsigned MODE_BITS      = 3;
  localparam int unsigned CFG_INDEX_BITS = 2;
  localparam int unsigned CFG_DATA_BITS  = 16;
  localparam int unsigned TURN_BITS      = 2;
  localparam int unsigned GAIN_BITS      = 6;

  localparam logic [MODE_BITS-1:0] MODE_SPRING = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_DAMPER = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_WALL   = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_OFF    = 3'd4;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_MODE = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_UNIT = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_WALL = 2'd2;

  localparam logic [UNIT_BITS-1:0] UNIT_RESET = 16'd15;
  localparam logic [POS_BITS-1:0]  WALL_RESET = 16'd13000;

  localparam logic [DIST_BITS-1:0] DIST_RESET = -18'sd100;

  localparam logic [16:0] WRAP_JUMP = 17'd15000;

  localparam logic [DIST_BITS-1:0] SPRING_TIER_1 = 18'd6000;
  localparam logic [DIST_BITS-1:0] SPRING_TIER_2 = 18'd12000;
  localparam logic [DIST_BITS-1:0] SPRING_TIER_3 = 18'd18000;
  localparam logic signed [DIST_BITS-1:0] DEAD_BAND = 18'sd50;

  localparam logic [GAIN_BITS-1:0] SPRING_GAIN_1 = 6'd37;
  localparam logic [GAIN_BITS-1:0] SPRING_GAIN_2 = 6'd38;
  localparam logic [GAIN_BITS-1:0] SPRING_GAIN_3 = 6'd39;
  localparam logic [GAIN_BITS-1:0] SPRING_GAIN_4 = 6'd40;
  localparam logic [GAIN_BITS-1:0] WALL_GAIN     = 6'd50;

  localparam logic [POS_BITS-1:0] WALL_RANGE = 16'd3000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FORCE,
    ST_COMMIT
  } state_t;

  typedef enum logic [1:0] {
    ACT_ZERO,
    ACT_FWD,
    ACT_REV,
    ACT_HOLD
  } action_t;

  typedef struct packed {
    logic capture;
    logic force_calc;
    logic commit;
  } cmd_t;

endpackage

`default_nettype wire

FILE: hdl/hfr_ctrl.sv
`default_nettype none

module hfr_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  output hfr_pkg::cmd_t      cmd
);

  hfr_pkg::state_t state;
  hfr_pkg::state_t state_next;
  logic            out_valid_next;

  always_comb begin
    state_next = state;
    unique case (state)
      hfr_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = hfr_pkg::ST_FORCE;
        end
      end
      hfr_pkg::ST_FORCE: begin
        state_next = hfr_pkg::ST_COMMIT;
      end
      hfr_pkg::ST_COMMIT: begin
        if (!out_valid || !out_stall) begin
          state_next = hfr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = hfr_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall       = (state != hfr_pkg::ST_IDLE);
    cmd.capture    = (state == hfr_pkg::ST_IDLE) && in_valid;
    cmd.force_calc = (state == hfr_pkg::ST_FORCE);
    cmd.commit     = (state == hfr_pkg::ST_COMMIT) && (!out_valid || !out_stall);
  end

  always_comb begin
    out_valid_next = out_valid;
    if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
    if (cmd.commit) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= hfr_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == hfr_pkg::ST_FORCE))
    else $error("accepted transfer did not start the force stage");

  assert property (@(posedge clk) disable iff (rst)
    (state == hfr_pkg::ST_FORCE) |=> (state == hfr_pkg::ST_COMMIT))
    else $error("force stage did not advance to commit");

  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == hfr_pkg::ST_COMMIT))
    else $error("result appeared without a commit");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall && state == hfr_pkg::ST_COMMIT) |=> out_valid)
    else $error("stalled result was dropped");

endmodule

`default_nettype wire

FILE: hdl/hfr_dp.sv
`default_nettype none

module hfr_dp #(
  parameter int unsigned ANGLE_BITS = 14
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire hfr_pkg::cmd_t                           cmd,
  input  wire logic [ANGLE_BITS-1:0]                   raw_angle,
  input  wire logic                                    cfg_we,
  input  wire logic [hfr_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
  input  wire logic [hfr_pkg::CFG_DATA_BITS-1:0]       cfg_data,
  output logic      [hfr_pkg::POS_BITS-1:0]            position,
  output logic      [hfr_pkg::POS_BITS-1:0]            drive_forward,
  output logic      [hfr_pkg::POS_BITS-1:0]            drive_reverse,
  output logic signed [hfr_pkg::REPORT_BITS-1:0]       motor_report
);

  localparam logic [hfr_pkg::DIST_BITS-1:0] CENTRE =
    hfr_pkg::DIST_BITS'(3 << (ANGLE_BITS - 1));

  logic [hfr_pkg::MODE_BITS-1:0]  mode;
  logic [hfr_pkg::UNIT_BITS-1:0]  duty_unit;
  logic [hfr_pkg::POS_BITS-1:0]   wall_position;

  logic [ANGLE_BITS-1:0]          last_angle;
  logic [hfr_pkg::TURN_BITS-1:0]  turn_count;
  logic [hfr_pkg::TURN_BITS-1:0]  turn_next;
  logic [hfr_pkg::POS_BITS-1:0]   last_position;
  logic signed [hfr_pkg::DIST_BITS-1:0] spring_distance;
  logic [hfr_pkg::POS_BITS-1:0]   pos_reg;

  logic [16:0]                    angle_fall;
  logic [16:0]                    angle_rise;
  logic [17:0]                    pos_sum;

  logic [hfr_pkg::DIST_BITS-1:0]  dist_mag;
  logic [hfr_pkg::GAIN_BITS-1:0]  spring_gain;
  logic                           damp_up;
  logic                           damp_down;
  logic [hfr_pkg::POS_BITS-1:0]   damp_mag;
  logic [hfr_pkg::POS_BITS-1:0]   damp_scaled;
  logic                           wall_above;
  logic                           wall_below;
  logic [hfr_pkg::POS_BITS-1:0]   wall_gap;

  logic [hfr_pkg::UNIT_BITS-1:0]  factor;
  hfr_pkg::action_t               action_calc;
  logic                           neg_calc;
  logic [31:0]                    product;

  logic [hfr_pkg::POS_BITS-1:0]   force_reg;
  hfr_pkg::action_t               action_reg;
  logic                           neg_reg;
  logic                           spring_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= hfr_pkg::MODE_OFF;
      duty_unit     <= hfr_pkg::UNIT_RESET;
      wall_position <= hfr_pkg::WALL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hfr_pkg::CFG_MODE: mode          <= cfg_data[hfr_pkg::MODE_BITS-1:0];
        hfr_pkg::CFG_UNIT: duty_unit     <= cfg_data;
        hfr_pkg::CFG_WALL: wall_position <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    angle_fall = 17'(last_angle) - 17'(raw_angle);
    angle_rise = 17'(raw_angle) - 17'(last_angle);
    turn_next  = turn_count;
    priority if (last_angle > raw_angle && angle_fall > hfr_pkg::WRAP_JUMP) begin
      turn_next = (turn_count >= 2'd2) ? 2'd0 : turn_count + 2'd1;
    end else if (last_angle < raw_angle && angle_rise > hfr_pkg::WRAP_JUMP) begin
      turn_next = (turn_count == 2'd0 || turn_count > 2'd2) ? 2'd2 : turn_count - 2'd1;
    end else begin
      turn_next = turn_count;
    end
    pos_sum = 18'(raw_angle) + (18'(turn_next) << ANGLE_BITS);
  end

  always_comb begin
    dist_mag = spring_distance[hfr_pkg::DIST_BITS-1] ?
               hfr_pkg::DIST_BITS'(-spring_distance) : spring_distance;
    priority if (dist_mag < hfr_pkg::SPRING_TIER_1) begin
      spring_gain = hfr_pkg::SPRING_GAIN_1;
    end else if (dist_mag < hfr_pkg::SPRING_TIER_2) begin
      spring_gain = hfr_pkg::SPRING_GAIN_2;
    end else if (dist_mag < hfr_pkg::SPRING_TIER_3) begin
      spring_gain = hfr_pkg::SPRING_GAIN_3;
    end else begin
      spring_gain = hfr_pkg::SPRING_GAIN_4;
    end

    damp_up     = {1'b0, pos_reg} > ({1'b0, last_position} + 17'd1);
    damp_down   = ({1'b0, pos_reg} + 17'd1) < {1'b0, last_position};
    damp_mag    = damp_up ? pos_reg - last_position : last_position - pos_reg;
    damp_scaled = (damp_mag << 2) + (damp_mag << 1);

    wall_above = pos_reg > wall_position;
    wall_below = pos_reg < wall_position;
    wall_gap   = wall_above ? pos_reg - wall_position : wall_position - pos_reg;

    factor      = '0;
    action_calc = hfr_pkg::ACT_ZERO;
    neg_calc    = 1'b0;
    unique case (mode)
      hfr_pkg::MODE_SPRING: begin
        factor = hfr_pkg::UNIT_BITS'(spring_gain);
        if (spring_distance < -hfr_pkg::DEAD_BAND) begin
          action_calc = hfr_pkg::ACT_REV;
        end else if (spring_distance > hfr_pkg::DEAD_BAND) begin
          action_calc = hfr_pkg::ACT_FWD;
        end
      end
      hfr_pkg::MODE_DAMPER: begin
        factor = damp_scaled;
        if (damp_up) begin
          action_calc = hfr_pkg::ACT_REV;
        end else if (damp_down) begin
          action_calc = hfr_pkg::ACT_FWD;
        end
      end
      hfr_pkg::MODE_WALL: begin
        factor = hfr_pkg::UNIT_BITS'(hfr_pkg::WALL_GAIN);
        if (wall_above) begin
          if (wall_gap < hfr_pkg::WALL_RANGE) begin
            action_calc = hfr_pkg::ACT_FWD;
          end
        end else if (wall_below) begin
          if (wall_gap < hfr_pkg::WALL_RANGE) begin
            action_calc = hfr_pkg::ACT_REV;
            neg_calc    = 1'b1;
          end
        end else begin
          action_calc = hfr_pkg::ACT_HOLD;
        end
      end
      default: begin
        action_calc = hfr_pkg::ACT_ZERO;
      end
    endcase

    product = factor * duty_unit;
  end

  always_ff @(posedge clk) begin
    if (cmd.force_calc) begin
      force_reg  <= product[hfr_pkg::POS_BITS-1:0];
      action_reg <= action_calc;
      neg_reg    <= neg_calc;
      spring_reg <= (mode == hfr_pkg::MODE_SPRING);
    end
    if (cmd.capture) begin
      pos_reg <= pos_sum[hfr_pkg::POS_BITS-1:0];
    end
    if (cmd.commit) begin
      position <= pos_reg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_angle      <= '0;
      turn_count      <= '0;
      last_position   <= '0;
      spring_distance <= hfr_pkg::DIST_RESET;
      drive_forward   <= '0;
      drive_reverse   <= '0;
      motor_report    <= '0;
    end else begin
      if (cmd.capture) begin
        last_angle <= raw_angle;
        turn_count <= turn_next;
      end
      if (cmd.commit) begin
        last_position <= pos_reg;
        if (spring_reg) begin
          spring_distance <= CENTRE - hfr_pkg::DIST_BITS'(pos_reg);
        end
        unique case (action_reg)
          hfr_pkg::ACT_ZERO: begin
            drive_forward <= '0;
            drive_reverse <= '0;
            motor_report  <= '0;
          end
          hfr_pkg::ACT_FWD: begin
            drive_forward <= force_reg;
            drive_reverse <= '0;
            motor_report  <= hfr_pkg::REPORT_BITS'(force_reg);
          end
          hfr_pkg::ACT_REV: begin
            drive_forward <= '0;
            drive_reverse <= force_reg;
            motor_report  <= neg_reg ? hfr_pkg::REPORT_BITS'(17'd0 - {1'b0, force_reg})
                                     : hfr_pkg::REPORT_BITS'(force_reg);
          end
          hfr_pkg::ACT_HOLD: begin
          end
          default: begin
          end
        endcase
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && action_reg == hfr_pkg::ACT_HOLD) |=>
      ($stable(drive_forward) && $stable(drive_reverse) && $stable(motor_report)))
    else $error("held drive changed");

  assert property (@(posedge clk) disable iff (rst)
    (cmd.force_calc && action_calc == hfr_pkg::ACT_HOLD) |-> (mode == hfr_pkg::MODE_WALL))
    else $error("hold outside wall mode");

  assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> (drive_forward == '0 || drive_reverse == '0))
    else $error("both drive outputs active");

endmodule

`default_nettype wire

FILE: hdl/haptic_force_renderer.sv
// After an input transfer the controller steps through the force and commit states; commit sets out_valid.
// in_stall is high in the force and commit states, so a new input is taken only back in idle.
// A result waiting under out_stall lets one more input transfer in; its commit then waits.
// Reset: rst is synchronous and active high; it restores the register defaults,
// clears the turn count, the held drive values, and sets the spring distance to -100.
`default_nettype none

module haptic_force_renderer #(
  parameter int unsigned ANGLE_BITS = 14
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [ANGLE_BITS-1:0]               raw_angle,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic      [hfr_pkg::POS_BITS-1:0]        position,
  output logic      [hfr_pkg::POS_BITS-1:0]        drive_forward,
  output logic      [hfr_pkg::POS_BITS-1:0]        drive_reverse,
  output logic signed [hfr_pkg::REPORT_BITS-1:0]   motor_report,
  input  wire logic                                cfg_we,
  input  wire logic [hfr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [hfr_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  hfr_pkg::cmd_t cmd;

  hfr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  hfr_dp #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .raw_angle     (raw_angle),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .position      (position),
    .drive_forward (drive_forward),
    .drive_reverse (drive_reverse),
    .motor_report  (motor_report)
  );

endmodule

`default_nettype wire
